[rtl/fcbu_pkg.sv]
// ----------------------------------------------------------------------------
// fcbu_pkg
// Types and constants shared by the FP compare and branch unit.
// ----------------------------------------------------------------------------
package fcbu_pkg;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_CMPS  = 3'd0;
    localparam logic [2:0] OP_CMPES = 3'd1;
    localparam logic [2:0] OP_CMPD  = 3'd2;
    localparam logic [2:0] OP_CMPED = 3'd3;
    localparam logic [2:0] OP_BRANCH = 3'd4;
    localparam logic [2:0] OP_LDFSR = 3'd5;

    // Trap codes.
    localparam logic [1:0] TRAP_NONE     = 2'd0;
    localparam logic [1:0] TRAP_DISABLED = 2'd1;
    localparam logic [1:0] TRAP_FP_EXC   = 2'd2;

    // Condition codes (fcc) and branch conditions.
    localparam logic [1:0] FCC_EQ = 2'd0;
    localparam logic [1:0] FCC_LT = 2'd1;
    localparam logic [1:0] FCC_GT = 2'd2;
    localparam logic [1:0] FCC_UN = 2'd3;
    localparam logic [3:0] COND_NEVER  = 4'b0000;
    localparam logic [3:0] COND_ALWAYS = 4'b1000;

    // Status word fields.
    localparam logic [2:0] FTT_IEEE   = 3'h1;
    localparam logic [2:0] FTT_INVREG = 3'h6;
    localparam logic [4:0] CEXC_NV    = 5'h10;

    // Infinity magnitudes.
    localparam logic [62:0] INF_D = 63'h7FF0_0000_0000_0000;
    localparam logic [62:0] INF_S = 63'h0000_0000_7F80_0000;

    // Result of a compare.
    typedef struct packed {
        logic [1:0] order;
        logic       nan;
    } cmp_res_t;

    // Result of a branch evaluation.
    typedef struct packed {
        logic        taken;
        logic [31:0] pc;
        logic [31:0] npc;
    } br_res_t;

endpackage

[rtl/fcbu_if.sv]
// ----------------------------------------------------------------------------
// fcbu_in_if / fcbu_out_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface fcbu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic               fp_enabled;
    logic [63:0]        value_a;
    logic [63:0]        value_b;
    logic [4:0]         reg_a;
    logic [4:0]         reg_b;
    logic [4:0]         reg_dest;
    logic [3:0]         cond;
    logic               annul_bit;
    logic signed [21:0] displacement;
    logic [31:0]        pc_in;
    logic [31:0]        npc_in;

    modport source (output valid, op, fp_enabled, value_a, value_b, reg_a, reg_b,
                    reg_dest, cond, annul_bit, displacement, pc_in, npc_in,
                    input ready);
    modport sink (input valid, op, fp_enabled, value_a, value_b, reg_a, reg_b,
                  reg_dest, cond, annul_bit, displacement, pc_in, npc_in,
                  output ready);
endinterface

interface fcbu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  trap_code;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic [31:0] next_npc;
    logic [31:0] status_word;

    modport source (output valid, trap_code, branch_taken, next_pc, next_npc,
                    status_word, input ready);
    modport sink (input valid, trap_code, branch_taken, next_pc, next_npc,
                  status_word, output ready);
endinterface

[rtl/fcbu_cmp.sv]
// ----------------------------------------------------------------------------
// fcbu_cmp
// Orders two IEEE operands, single or double, and flags a NaN operand.
// ----------------------------------------------------------------------------
module fcbu_cmp
    import fcbu_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic        dbl,
    output cmp_res_t    res
);
    logic [62:0] ma;
    logic [62:0] mb;
    logic [62:0] inf;
    logic        sa;
    logic        sb;
    logic        nan_a;
    logic        nan_b;

    // Split sign and magnitude for the selected format.
    assign ma  = dbl ? a[62:0] : {32'd0, a[30:0]};
    assign mb  = dbl ? b[62:0] : {32'd0, b[30:0]};
    assign sa  = dbl ? a[63] : a[31];
    assign sb  = dbl ? b[63] : b[31];
    assign inf = dbl ? INF_D : INF_S;
    assign nan_a = ma > inf;
    assign nan_b = mb > inf;

    // Order: unordered, both zero, sign difference, then magnitude.
    always_comb
    begin
        res.nan = nan_a | nan_b;
        if (nan_a || nan_b)
            res.order = FCC_UN;
        else if (ma == 63'd0 && mb == 63'd0)
            res.order = FCC_EQ;
        else if (sa != sb)
            res.order = sa ? FCC_LT : FCC_GT;
        else if (ma == mb)
            res.order = FCC_EQ;
        else if (!sa)
            res.order = (ma < mb) ? FCC_LT : FCC_GT;
        else
            res.order = (ma > mb) ? FCC_LT : FCC_GT;
    end
endmodule

[rtl/fcbu_branch.sv]
// ----------------------------------------------------------------------------
// fcbu_branch
// Evaluates an FP branch condition and forms the next pc and npc.
// ----------------------------------------------------------------------------
module fcbu_branch
    import fcbu_pkg::*;
(
    input  logic [3:0]         cond,
    input  logic [1:0]         fcc,
    input  logic               annul_bit,
    input  logic signed [21:0] displacement,
    input  logic [31:0]        pc_in,
    input  logic [31:0]        npc_in,
    output br_res_t            res
);
    logic        e, l, g, u;
    logic        br;
    logic        annul;
    logic [31:0] target;
    logic [31:0] npc_new;

    assign e = fcc == FCC_EQ;
    assign l = fcc == FCC_LT;
    assign g = fcc == FCC_GT;
    assign u = fcc == FCC_UN;

    // Condition decode.
    always_comb
    begin
        unique case (cond)
            4'd0:    br = 1'b0;
            4'd1:    br = !e;
            4'd2:    br = l | g;
            4'd3:    br = u | l;
            4'd4:    br = l;
            4'd5:    br = u | g;
            4'd6:    br = g;
            4'd7:    br = u;
            4'd8:    br = 1'b1;
            4'd9:    br = e;
            4'd10:   br = u | e;
            4'd11:   br = g | e;
            4'd12:   br = u | g | e;
            4'd13:   br = l | e;
            4'd14:   br = u | l | e;
            default: br = !u;
        endcase
    end

    // A taken conditional branch never annuls its delay slot.
    assign annul  = annul_bit && !(br && cond != COND_NEVER && cond != COND_ALWAYS);
    assign target = pc_in + {{8{displacement[21]}}, displacement, 2'b00};
    assign npc_new = br ? target : npc_in + 32'd4;

    always_comb
    begin
        res.taken = br;
        res.pc    = annul ? npc_new : npc_in;
        res.npc   = annul ? npc_new + 32'd4 : npc_new;
    end
endmodule

[rtl/fp_compare_and_branch_unit_top.sv]
// ----------------------------------------------------------------------------
// fp_compare_and_branch_unit_top
// FP status unit: compares, FP branches and status loads.
// ----------------------------------------------------------------------------
// Each input beat is evaluated combinationally against the current status word
// and its result lands in an output register, which also commits the new
// status word; a beat can be accepted every cycle, and the input stays ready
// while the output register is empty or being drained. Result valid rises in
// the cycle after input accept, set by the single result register.
module fp_compare_and_branch_unit_top
    import fcbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fcbu_in_if.sink     in_ch,
    fcbu_out_if.source  out_ch
);
    logic        accept;
    logic        valid_reg;
    logic [31:0] status_reg;
    logic [31:0] status_next;
    logic [1:0]  trap_reg, trap_next;
    logic        taken_reg, taken_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] npc_reg, npc_next;
    logic        dbl;
    logic        odd_reg;
    cmp_res_t    cmp;
    br_res_t     br;

    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign dbl     = in_ch.op[1];
    assign odd_reg = in_ch.reg_a[0] | in_ch.reg_b[0] | in_ch.reg_dest[0];

    fcbu_cmp u_cmp (
        .a   (in_ch.value_a),
        .b   (in_ch.value_b),
        .dbl (dbl),
        .res (cmp)
    );

    fcbu_branch u_branch (
        .cond         (in_ch.cond),
        .fcc          (status_reg[11:10]),
        .annul_bit    (in_ch.annul_bit),
        .displacement (in_ch.displacement),
        .pc_in        (in_ch.pc_in),
        .npc_in       (in_ch.npc_in),
        .res          (br)
    );

    // Per-op result and status update.
    always_comb
    begin
        status_next = status_reg;
        trap_next   = TRAP_NONE;
        taken_next  = 1'b0;
        pc_next     = in_ch.npc_in;
        npc_next    = in_ch.npc_in + 32'd4;
        if (in_ch.op <= OP_LDFSR && !in_ch.fp_enabled)
        begin
            trap_next = TRAP_DISABLED;
        end
        else
        begin
            unique case (in_ch.op)
                OP_CMPS, OP_CMPES, OP_CMPD, OP_CMPED:
                begin
                    if (dbl && odd_reg)
                    begin
                        status_next[16:14] = FTT_INVREG;
                        trap_next = TRAP_FP_EXC;
                    end
                    else if (in_ch.op[0] && cmp.nan)
                    begin
                        status_next[16:14] = FTT_IEEE;
                        status_next[4:0]   = CEXC_NV;
                        trap_next = TRAP_FP_EXC;
                    end
                    else
                    begin
                        status_next[11:10] = cmp.order;
                    end
                end
                OP_BRANCH:
                begin
                    taken_next = br.taken;
                    pc_next    = br.pc;
                    npc_next   = br.npc;
                end
                OP_LDFSR:
                begin
                    status_next = in_ch.value_a[31:0];
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
        if (trap_next != TRAP_NONE)
        begin
            pc_next  = in_ch.pc_in;
            npc_next = in_ch.npc_in;
        end
    end

    // Control state and committed status word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= 32'd0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg  <= 1'b1;
                status_reg <= status_next;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trap_reg  <= trap_next;
            taken_reg <= taken_next;
            pc_reg    <= pc_next;
            npc_reg   <= npc_next;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.trap_code    = trap_reg;
    assign out_ch.branch_taken = taken_reg;
    assign out_ch.next_pc      = pc_reg;
    assign out_ch.next_npc     = npc_reg;
    assign out_ch.status_word  = status_reg;

    // The shown status word is always the committed one.
    a_status_track: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_ch.status_word == status_reg)
        else $error("result status differs from committed status");

    // A trapped beat never reports a taken branch.
    a_trap_no_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.trap_code != TRAP_NONE |-> !out_ch.branch_taken)
        else $error("taken branch on trap");

    // FP disabled leaves the status word alone.
    a_disabled_keep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_ch.fp_enabled && in_ch.op <= OP_LDFSR
        |=> status_reg == $past(status_reg))
        else $error("status changed while FP disabled");

    // A load-status beat writes the operand word.
    a_ldfsr: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.fp_enabled && in_ch.op == OP_LDFSR
        |=> status_reg == $past(in_ch.value_a[31:0]))
        else $error("load status not written");
endmodule

[sim/tb_fp_compare_and_branch_unit_top.sv]
// ----------------------------------------------------------------------------
// tb_fp_compare_and_branch_unit_top
// Drives compare, branch and status-load beats into the FP status unit under
// random idling on both channels. A local model predicts every result beat,
// and each beat out of the unit is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_fp_compare_and_branch_unit_top;
    import fcbu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1950;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // One input beat.
    typedef struct packed {
        logic [2:0]         op;
        logic               fp_enabled;
        logic [63:0]        value_a;
        logic [63:0]        value_b;
        logic [4:0]         reg_a;
        logic [4:0]         reg_b;
        logic [4:0]         reg_dest;
        logic [3:0]         cond;
        logic               annul_bit;
        logic signed [21:0] displacement;
        logic [31:0]        pc_in;
        logic [31:0]        npc_in;
    } instr_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]  trap_code;
        logic        branch_taken;
        logic [31:0] next_pc;
        logic [31:0] next_npc;
        logic [31:0] status_word;
    } outcome_t;

    // A directed row; a known outcome is checked against the prediction too.
    typedef struct {
        instr_t   ins;
        bit       known;
        outcome_t want;
    } row_t;

    logic clk;
    logic rst_n;

    fcbu_in_if  in_ch ();
    fcbu_out_if out_ch ();

    fp_compare_and_branch_unit_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    logic [31:0] model_fsr = '0;
    outcome_t    pending_outcomes[$];
    int          mismatches;
    int          quiet_cycles = 0;
    bit          no_idle;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Report one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [98:0] got,
                                   input logic [98:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Ordering of two IEEE values: EQ, LT, GT or UN.
    function automatic logic [1:0] ieee_order(input logic [63:0] a, input logic [63:0] b,
                                              input bit dbl);
        logic [62:0] ma;
        logic [62:0] mb;
        logic [62:0] inf;
        logic        sa;
        logic        sb;
        inf = dbl ? INF_D : INF_S;
        ma  = dbl ? a[62:0] : {32'd0, a[30:0]};
        mb  = dbl ? b[62:0] : {32'd0, b[30:0]};
        sa  = dbl ? a[63] : a[31];
        sb  = dbl ? b[63] : b[31];
        if (ma > inf || mb > inf) return FCC_UN;
        if (ma == 0 && mb == 0) return FCC_EQ;
        if (sa != sb) return sa ? FCC_LT : FCC_GT;
        if (ma == mb) return FCC_EQ;
        if (!sa) return (ma < mb) ? FCC_LT : FCC_GT;
        return (ma > mb) ? FCC_LT : FCC_GT;
    endfunction

    // Whether a branch condition holds on fcc.
    function automatic bit fcc_cond_holds(input logic [3:0] c, input logic [1:0] fcc);
        bit e;
        bit l;
        bit g;
        bit u;
        e = fcc == FCC_EQ;
        l = fcc == FCC_LT;
        g = fcc == FCC_GT;
        u = fcc == FCC_UN;
        case (c)
            4'd0:    return 1'b0;
            4'd1:    return !e;
            4'd2:    return l || g;
            4'd3:    return u || l;
            4'd4:    return l;
            4'd5:    return u || g;
            4'd6:    return g;
            4'd7:    return u;
            4'd8:    return 1'b1;
            4'd9:    return e;
            4'd10:   return u || e;
            4'd11:   return g || e;
            4'd12:   return u || g || e;
            4'd13:   return l || e;
            4'd14:   return u || l || e;
            default: return !u;
        endcase
    endfunction

    // Predict the outcome of one beat and advance the status word.
    function automatic outcome_t predict_fsr_step(input instr_t x);
        outcome_t    r;
        logic [63:0] a;
        logic [63:0] b;
        logic [62:0] inf;
        logic [31:0] target;
        bit          dbl;
        bit          sig;
        bit          nan;
        bit          taken;
        bit          annul;
        r.trap_code    = TRAP_NONE;
        r.branch_taken = 1'b0;
        r.next_pc      = x.npc_in;
        r.next_npc     = x.npc_in + 32'd4;
        if (x.op <= OP_LDFSR && !x.fp_enabled)
        begin
            r.trap_code = TRAP_DISABLED;
        end
        else if (x.op <= OP_CMPED)
        begin
            dbl = x.op >= OP_CMPD;
            sig = x.op[0];
            a   = dbl ? x.value_a : {32'd0, x.value_a[31:0]};
            b   = dbl ? x.value_b : {32'd0, x.value_b[31:0]};
            inf = dbl ? INF_D : INF_S;
            nan = (dbl ? a[62:0] : {32'd0, a[30:0]}) > inf
                || (dbl ? b[62:0] : {32'd0, b[30:0]}) > inf;
            if (dbl && (x.reg_a[0] | x.reg_b[0] | x.reg_dest[0]))
            begin
                model_fsr[16:14] = FTT_INVREG;
                r.trap_code = TRAP_FP_EXC;
            end
            else if (sig && nan)
            begin
                model_fsr[16:14] = FTT_IEEE;
                model_fsr[4:0]   = CEXC_NV;
                r.trap_code = TRAP_FP_EXC;
            end
            else
            begin
                model_fsr[11:10] = ieee_order(a, b, dbl);
            end
        end
        else if (x.op == OP_BRANCH)
        begin
            taken  = fcc_cond_holds(x.cond, model_fsr[11:10]);
            annul  = x.annul_bit;
            target = x.pc_in + {{8{x.displacement[21]}}, x.displacement, 2'b00};
            if (taken && x.cond != COND_NEVER && x.cond != COND_ALWAYS) annul = 1'b0;
            r.next_pc  = x.npc_in;
            r.next_npc = taken ? target : x.npc_in + 32'd4;
            if (annul)
            begin
                r.next_pc  = r.next_npc;
                r.next_npc = r.next_npc + 32'd4;
            end
            r.branch_taken = taken;
        end
        else if (x.op == OP_LDFSR)
        begin
            model_fsr = x.value_a[31:0];
        end
        if (r.trap_code != TRAP_NONE)
        begin
            r.next_pc  = x.pc_in;
            r.next_npc = x.npc_in;
        end
        r.status_word = model_fsr;
        return r;
    endfunction

    // IEEE operand with bias toward special values.
    function automatic logic [63:0] rand_operand(input bit dbl);
        logic [63:0] v;
        logic [63:0] hi;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = dbl ? {v[63], 63'd0} : {v[63:32], v[31], 31'd0};
            1: v = dbl ? {v[63], 11'h7FF, 52'd0} : {v[63:32], v[31], 8'hFF, 23'd0};
            2: v = dbl ? {v[63], 11'h7FF, v[51:0] | 52'd1}
                       : {v[63:32], v[31], 8'hFF, v[22:0] | 23'd1};
            3: v = dbl ? {v[63], 11'h000, v[51:0]} : {v[63:32], v[31], 8'h00, v[22:0]};
            4: v[3:0] = 4'd0;
            default: ;
        endcase
        hi = v;
        return hi;
    endfunction

    function automatic instr_t rand_instr(input int mode);
        instr_t x;
        int     pick;
        bit     dbl;
        x.op           = 3'($urandom_range(0, 5));
        pick           = $urandom_range(0, 99);
        if (pick < 3) x.op = 3'($urandom_range(6, 7));
        x.fp_enabled   = ($urandom_range(0, 19) != 0);
        dbl            = x.op == OP_CMPD || x.op == OP_CMPED;
        x.value_a      = rand_operand(dbl);
        x.value_b      = ($urandom_range(0, 3) == 0) ? x.value_a : rand_operand(dbl);
        if ($urandom_range(0, 5) == 0) x.value_b = x.value_a ^ (64'd1 << $urandom_range(0, 63));
        x.reg_a        = 5'($urandom);
        x.reg_b        = 5'($urandom);
        x.reg_dest     = 5'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            x.reg_a[0]    = 1'b0;
            x.reg_b[0]    = 1'b0;
            x.reg_dest[0] = 1'b0;
        end
        x.cond         = 4'($urandom);
        x.annul_bit    = 1'($urandom);
        x.displacement = 22'($urandom);
        x.pc_in        = $urandom;
        x.npc_in       = $urandom;
        if (x.op == OP_LDFSR && mode == 0) x.value_a[63:32] = $urandom;
        return x;
    endfunction

    // Base beat for directed rows.
    function automatic instr_t base_instr(input logic [2:0] op);
        instr_t x;
        x = '0;
        x.op         = op;
        x.fp_enabled = 1'b1;
        x.pc_in      = 32'h0000_1000;
        x.npc_in     = 32'h0000_1004;
        return x;
    endfunction

    // Send one beat, with a random burst of idling beforehand.
    task automatic send_beat(input instr_t x);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= x.op;
        in_ch.fp_enabled   <= x.fp_enabled;
        in_ch.value_a      <= x.value_a;
        in_ch.value_b      <= x.value_b;
        in_ch.reg_a        <= x.reg_a;
        in_ch.reg_b        <= x.reg_b;
        in_ch.reg_dest     <= x.reg_dest;
        in_ch.cond         <= x.cond;
        in_ch.annul_bit    <= x.annul_bit;
        in_ch.displacement <= x.displacement;
        in_ch.pc_in        <= x.pc_in;
        in_ch.npc_in       <= x.npc_in;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Predictions are pushed at the accepting edge so ordering is exact.
    always @(posedge clk)
    begin
        instr_t   x;
        outcome_t o;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            x.op           = in_ch.op;
            x.fp_enabled   = in_ch.fp_enabled;
            x.value_a      = in_ch.value_a;
            x.value_b      = in_ch.value_b;
            x.reg_a        = in_ch.reg_a;
            x.reg_b        = in_ch.reg_b;
            x.reg_dest     = in_ch.reg_dest;
            x.cond         = in_ch.cond;
            x.annul_bit    = in_ch.annul_bit;
            x.displacement = in_ch.displacement;
            x.pc_in        = in_ch.pc_in;
            x.npc_in       = in_ch.npc_in;
            o = predict_fsr_step(x);
            pending_outcomes.push_back(o);
        end
    end

    // Check each accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected beat", 99'(out_ch.status_word), '0);
            end
            else
            begin
                w = pending_outcomes.pop_front();
                if (out_ch.trap_code !== w.trap_code)
                    report_mismatch("trap_code", 99'(out_ch.trap_code), 99'(w.trap_code));
                if (out_ch.branch_taken !== w.branch_taken)
                    report_mismatch("branch_taken", 99'(out_ch.branch_taken),
                                    99'(w.branch_taken));
                if (out_ch.next_pc !== w.next_pc)
                    report_mismatch("next_pc", 99'(out_ch.next_pc), 99'(w.next_pc));
                if (out_ch.next_npc !== w.next_npc)
                    report_mismatch("next_npc", 99'(out_ch.next_npc), 99'(w.next_npc));
                if (out_ch.status_word !== w.status_word)
                    report_mismatch("status_word", 99'(out_ch.status_word),
                                    99'(w.status_word));
            end
        end
    end

    // Result-side stalls in random bursts.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        row_t   rows[$];
        row_t   r;
        instr_t x;
        int     i;
        mismatches   = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        x = base_instr(OP_CMPS);
        in_ch.op = x.op; in_ch.fp_enabled = 1'b1; in_ch.value_a = '0; in_ch.value_b = '0;
        in_ch.reg_a = '0; in_ch.reg_b = '0; in_ch.reg_dest = '0; in_ch.cond = '0;
        in_ch.annul_bit = 1'b0; in_ch.displacement = '0; in_ch.pc_in = '0;
        in_ch.npc_in = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows.
        // Branch always right after reset, zero displacement.
        r.ins = base_instr(OP_BRANCH); r.ins.cond = COND_ALWAYS;
        r.known = 1; r.want = '{TRAP_NONE, 1'b1, 32'h1004, 32'h1000, 32'h0};
        rows.push_back(r);
        // FP disabled.
        r.ins = base_instr(OP_CMPD); r.ins.fp_enabled = 1'b0;
        r.known = 1; r.want = '{TRAP_DISABLED, 1'b0, 32'h1000, 32'h1004, 32'h0};
        rows.push_back(r);
        // Odd double register.
        r.ins = base_instr(OP_CMPD); r.ins.reg_dest = 5'd1;
        r.known = 1; r.want = '{TRAP_FP_EXC, 1'b0, 32'h1000, 32'h1004, 32'h0001_8000};
        rows.push_back(r);
        // Load status with all ones, then zero.
        r.ins = base_instr(OP_LDFSR); r.ins.value_a = '1;
        r.known = 1; r.want = '{TRAP_NONE, 1'b0, 32'h1004, 32'h1008, 32'hFFFF_FFFF};
        rows.push_back(r);
        r.ins = base_instr(OP_LDFSR);
        r.known = 1; r.want = '{TRAP_NONE, 1'b0, 32'h1004, 32'h1008, 32'h0};
        rows.push_back(r);
        // Signaling single compare with NaN.
        r.ins = base_instr(OP_CMPES); r.ins.value_b = 64'h7FC0_0000;
        r.known = 1; r.want = '{TRAP_FP_EXC, 1'b0, 32'h1000, 32'h1004, 32'h0000_4010};
        rows.push_back(r);
        r.known = 0;
        // Plus and minus zero, a NaN, infinities, double orderings.
        r.ins = base_instr(OP_CMPS); r.ins.value_a = 64'h8000_0000; rows.push_back(r);
        r.ins = base_instr(OP_CMPS); r.ins.value_b = 64'h7F80_0001; rows.push_back(r);
        r.ins = base_instr(OP_CMPS); r.ins.value_a = 64'hFF80_0000;
        r.ins.value_b = 64'h7F80_0000; rows.push_back(r);
        r.ins = base_instr(OP_CMPD); r.ins.value_a = 64'h7FF0_0000_0000_0000; rows.push_back(r);
        r.ins = base_instr(OP_CMPED); r.ins.value_a = 64'hBFF0_0000_0000_0000;
        r.ins.value_b = 64'hC000_0000_0000_0000; rows.push_back(r);
        r.ins = base_instr(OP_CMPED); r.ins.value_a = '1; rows.push_back(r);
        r.ins = base_instr(OP_CMPD); r.ins.value_a = 64'h8000_0000_0000_0000; rows.push_back(r);
        // Branches with annul, extreme displacements and pc wrap.
        for (i = 0; i < 8; i++)
        begin
            r.ins = base_instr(OP_BRANCH);
            r.ins.cond = 4'(i * 2 + (i & 1));
            r.ins.annul_bit = 1'b1;
            r.ins.displacement = (i & 2) ? 22'sh1FFFFF : -22'sh200000;
            r.ins.pc_in = 32'hFFFF_FFFC; r.ins.npc_in = 32'hFFFF_FFFC;
            rows.push_back(r);
        end
        r.ins = base_instr(OP_SPARE6); r.ins.fp_enabled = 1'b0; rows.push_back(r);
        r.ins = base_instr(OP_SPARE7); rows.push_back(r);

        foreach (rows[k])
        begin
            send_beat(rows[k].ins);
            if (rows[k].known)
            begin
                // The prediction for this row was pushed at the accepting edge.
                if (pending_outcomes[pending_outcomes.size() - 1] !== rows[k].want)
                    report_mismatch("directed prediction",
                                    pending_outcomes[pending_outcomes.size() - 1],
                                    rows[k].want);
            end
        end
        in_ch.valid <= 1'b0;

        // Random part; at one point the sender waits for the pipe to drain.
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                in_ch.valid <= 1'b0;
                while (pending_outcomes.size() != 0) @(negedge clk);
            end
            if (i == N_RANDOM - 200) no_idle = 1'b1;
            send_beat(rand_instr(i & 1));
        end
        in_ch.valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
